// ===== hdl/wxt_pkg.sv =====
// Shared types, character codes and match pattern tables for the word XML
// text extractor. No dependencies; imported by every module of the block.
`default_nettype none

package wxt_pkg;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_W     = 8'h77;

    localparam int NPAT   = 5;
    localparam int PATLEN = 6;
    localparam logic [2:0] MAX_HELD = 3'd5;

    // Tag patterns seen outside runs
    localparam logic [2:0] OP_RUN      = 3'd0;   // <w:t>
    localparam logic [2:0] OP_RUN_ATTR = 3'd1;   // <w:t + space
    localparam logic [2:0] OP_PARA     = 3'd2;   // </w:p>
    localparam logic [2:0] OP_TAB      = 3'd3;   // <w:tab
    localparam logic [2:0] OP_BR       = 3'd4;   // <w:br

    localparam logic [7:0] OUTER_PAT [NPAT][PATLEN] = '{
        '{CH_LT, CH_W,     CH_COLON, CH_T,     CH_GT, 8'h00},
        '{CH_LT, CH_W,     CH_COLON, CH_T,     CH_SP, 8'h00},
        '{CH_LT, CH_SLASH, CH_W,     CH_COLON, CH_P,  CH_GT},
        '{CH_LT, CH_W,     CH_COLON, CH_T,     CH_A,  CH_B},
        '{CH_LT, CH_W,     CH_COLON, CH_B,     CH_R,  8'h00}
    };
    localparam logic [2:0] OUTER_LEN [NPAT] = '{3'd5, 3'd5, 3'd6, 3'd6, 3'd5};

    localparam logic [7:0] ENT_PAT [NPAT][PATLEN] = '{
        '{CH_AMP, CH_A, CH_M, CH_P, CH_SEMI, 8'h00},
        '{CH_AMP, CH_L, CH_T, CH_SEMI, 8'h00, 8'h00},
        '{CH_AMP, CH_G, CH_T, CH_SEMI, 8'h00, 8'h00},
        '{CH_AMP, CH_Q, CH_U, CH_O, CH_T, CH_SEMI},
        '{CH_AMP, CH_A, CH_P, CH_O, CH_S, CH_SEMI}
    };
    localparam logic [2:0] ENT_LEN [NPAT] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6};
    localparam logic [7:0] ENT_VAL [NPAT] = '{CH_AMP, CH_LT, CH_GT, CH_DQ, CH_SQ};

    localparam logic [7:0] CLOSE_PAT [PATLEN] =
        '{CH_LT, CH_SLASH, CH_W, CH_COLON, CH_T, CH_GT};

    typedef enum logic [1:0] {
        MODE_OUT  = 2'd0,   // outside runs
        MODE_SKIP = 2'd1,   // inside an opening run tag, waiting for '>'
        MODE_TEXT = 2'd2    // copying run text
    } mode_t;

    // Source of held bytes that get flushed raw: one of the entities or
    // the run close tag.
    typedef enum logic [2:0] {
        FL_AMP   = 3'd0,
        FL_LT    = 3'd1,
        FL_GT    = 3'd2,
        FL_QUOT  = 3'd3,
        FL_APOS  = 3'd4,
        FL_CLOSE = 3'd5
    } flush_src_t;

    typedef struct packed {
        mode_t      mode;
        logic [2:0] pos;
        logic [4:0] mask;
    } scan_t;

    // Compact description of all beats one input byte produces:
    // flushed held bytes, then an optional byte, then an optional end beat.
    typedef struct packed {
        flush_src_t flush_src;
        logic [2:0] flush_cnt;
        logic       extra_vld;
        logic [7:0] extra_byte;
        logic       end_vld;
    } res_t;

    function automatic logic [7:0] flush_char(flush_src_t src, logic [2:0] idx);
        logic [7:0] ch;
        if (src == FL_CLOSE)
            ch = CLOSE_PAT[idx];
        else
            ch = ENT_PAT[src][idx];
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/wxt_step.sv =====
// Per-byte scan logic: next match state and beat description for one byte.
// Depends on wxt_pkg.
`default_nettype none

module wxt_step (
    input  wire logic          [7:0] in_byte,
    input  wire logic                is_final,
    input  wire wxt_pkg::scan_t      cur,
    output wxt_pkg::scan_t           nxt,
    output wxt_pkg::res_t            res
);
    import wxt_pkg::*;

    logic [4:0]  ent_hit;
    logic [4:0]  out_hit;
    logic        ent_done_vld;
    flush_src_t  ent_done_idx;
    logic        out_done_vld;
    logic [2:0]  out_done_idx;
    flush_src_t  first_cand;
    logic        fresh;
    logic        held_ok;

    // Candidate advance for both pattern sets, five independent lanes
    always_comb
    begin
        ent_done_vld = 1'b0;
        ent_done_idx = FL_AMP;
        out_done_vld = 1'b0;
        out_done_idx = OP_RUN;
        first_cand   = FL_AMP;
        for (int i = NPAT - 1; i >= 0; i--)
        begin
            ent_hit[i] = cur.mask[i] && (cur.pos < ENT_LEN[i]) &&
                         (ENT_PAT[i][cur.pos] == in_byte);
            out_hit[i] = cur.mask[i] && (cur.pos < OUTER_LEN[i]) &&
                         (OUTER_PAT[i][cur.pos] == in_byte);
            // descending loop: lowest index wins
            if (ent_hit[i] && (ENT_LEN[i] == cur.pos + 3'd1))
            begin
                ent_done_vld = 1'b1;
                ent_done_idx = flush_src_t'(3'(i));
            end
            if (out_hit[i] && (OUTER_LEN[i] == cur.pos + 3'd1))
            begin
                out_done_vld = 1'b1;
                out_done_idx = 3'(i);
            end
            if (cur.mask[i])
                first_cand = flush_src_t'(3'(i));
        end
    end

    assign held_ok = (cur.pos != 3'd0) && (cur.pos <= MAX_HELD);

    always_comb
    begin
        nxt = cur;
        res = '{flush_src: FL_AMP, flush_cnt: 3'd0, extra_vld: 1'b0,
                extra_byte: 8'h00, end_vld: 1'b0};
        fresh = 1'b0;

        unique case (cur.mode)
            MODE_SKIP:
            begin
                if (in_byte == CH_GT)
                    nxt.mode = MODE_TEXT;
            end
            MODE_TEXT:
            begin
                if (!held_ok)
                begin
                    nxt.pos  = 3'd0;
                    nxt.mask = 5'd0;
                    fresh    = 1'b1;
                end
                else if (cur.mask != 5'd0)
                begin
                    if (ent_done_vld)
                    begin
                        nxt.pos        = 3'd0;
                        nxt.mask       = 5'd0;
                        res.extra_vld  = 1'b1;
                        res.extra_byte = ENT_VAL[ent_done_idx];
                    end
                    else if (ent_hit != 5'd0)
                    begin
                        nxt.mask = ent_hit;
                        nxt.pos  = cur.pos + 3'd1;
                    end
                    else
                    begin
                        res.flush_src = first_cand;
                        res.flush_cnt = cur.pos;
                        nxt.pos       = 3'd0;
                        nxt.mask      = 5'd0;
                        fresh         = 1'b1;
                    end
                end
                else if (CLOSE_PAT[cur.pos] == in_byte)
                begin
                    if (cur.pos == MAX_HELD)
                    begin
                        nxt.pos  = 3'd0;
                        nxt.mask = 5'd0;
                        nxt.mode = MODE_OUT;
                    end
                    else
                        nxt.pos = cur.pos + 3'd1;
                end
                else
                begin
                    res.flush_src = FL_CLOSE;
                    res.flush_cnt = cur.pos;
                    nxt.pos       = 3'd0;
                    nxt.mask      = 5'd0;
                    fresh         = 1'b1;
                end
            end
            default:
            begin
                // outside runs; the unused mode code lands here too
                nxt.mode = MODE_OUT;
                if (held_ok && out_done_vld)
                begin
                    nxt.pos  = 3'd0;
                    nxt.mask = 5'd0;
                    unique case (out_done_idx)
                        OP_RUN:      nxt.mode = MODE_TEXT;
                        OP_RUN_ATTR: nxt.mode = MODE_SKIP;
                        OP_TAB:
                        begin
                            res.extra_vld  = 1'b1;
                            res.extra_byte = CH_TAB;
                        end
                        default:
                        begin
                            res.extra_vld  = 1'b1;
                            res.extra_byte = CH_NL;
                        end
                    endcase
                end
                else if (held_ok && (out_hit != 5'd0))
                begin
                    nxt.mask = out_hit;
                    nxt.pos  = cur.pos + 3'd1;
                end
                else if (in_byte == CH_LT)
                begin
                    nxt.pos  = 3'd1;
                    nxt.mask = 5'h1F;
                end
                else
                begin
                    nxt.pos  = 3'd0;
                    nxt.mask = 5'd0;
                end
            end
        endcase

        // run text byte with nothing held: start a match or copy it
        if (fresh)
        begin
            if (in_byte == CH_AMP)
            begin
                nxt.pos  = 3'd1;
                nxt.mask = 5'h1F;
            end
            else if (in_byte == CH_LT)
            begin
                nxt.pos  = 3'd1;
                nxt.mask = 5'd0;
            end
            else
            begin
                res.extra_vld  = 1'b1;
                res.extra_byte = in_byte;
            end
        end

        if (is_final)
        begin
            nxt.mode    = MODE_OUT;
            nxt.pos     = 3'd0;
            nxt.mask    = 5'd0;
            res.end_vld = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wxt_out.sv =====
// Result register and beat serializer: holds one byte's beat description and
// walks it out one beat per handshake. Depends on wxt_pkg.
`default_nettype none

module wxt_out (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire wxt_pkg::res_t       res,
    output logic                     free,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic               [7:0] m_tdata,   // [7:0] out_byte
    output logic               [1:0] m_tuser,   // [0] has_byte, [1] doc_end
    output logic                     m_tlast    // run_last
);
    import wxt_pkg::*;

    res_t       res_reg;
    logic       buf_valid_reg;
    logic       buf_valid_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic [2:0] total;
    logic       last;
    logic       beat;

    assign total = res_reg.flush_cnt + {2'b00, res_reg.extra_vld} +
                   {2'b00, res_reg.end_vld};
    assign last  = (idx_reg == total - 3'd1);
    assign beat  = buf_valid_reg && m_tready;
    assign free  = !buf_valid_reg || (m_tready && last);

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            buf_valid_next = 1'b1;
            idx_next       = 3'd0;
        end
        else if (beat)
        begin
            if (last)
                buf_valid_next = 1'b0;
            else
                idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    always_comb
    begin
        m_tdata = 8'h00;
        m_tuser = 2'b00;
        priority if (idx_reg < res_reg.flush_cnt)
        begin
            m_tdata    = flush_char(res_reg.flush_src, idx_reg);
            m_tuser[0] = 1'b1;
        end
        else if (res_reg.extra_vld && (idx_reg == res_reg.flush_cnt))
        begin
            m_tdata    = res_reg.extra_byte;
            m_tuser[0] = 1'b1;
        end
        else
            m_tuser[1] = 1'b1;
    end

    assign m_tvalid = buf_valid_reg;
    assign m_tlast  = last;

endmodule

`default_nettype wire

// ===== hdl/word_xml_text_extractor.sv =====
// Top level of the word XML text extractor: input register, scan state and
// result serializer. Depends on wxt_pkg, wxt_step and wxt_out.
`default_nettype none

// Takes the body of a word-processing XML document one byte per beat on the
// s_ side (s_tlast marks the document's last byte) and streams out its plain
// text on the m_ side. Outside text runs, a paragraph close gives a newline,
// a break tag gives a newline and a tab tag gives a tab; everything else is
// dropped. A run open tag (with or without attributes) starts copying, with
// the five standard entities decoded, until the run close tag. A partial
// entity or close tag that fails inside a run is emitted raw. Each input byte
// yields zero to seven output beats; m_tlast flags the last beat of one input
// byte, m_tuser[0] says the beat carries a text byte and m_tuser[1] marks the
// extra closing beat that follows the final document byte (a run cut off by
// the end of input keeps the text it already gave; a held partial match is
// dropped there). Rate: one input byte per cycle while each byte gives at
// most one beat and m_tready stays high; a byte that gives more beats holds the
// input side while the single output register serializes them. A byte passes
// through the input register and then the result register before its first beat.
module word_xml_text_extractor (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] in_byte
    input  wire logic       s_tlast,    // is_final
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,    // [7:0] out_byte
    output logic      [1:0] m_tuser,    // [0] has_byte, [1] doc_end
    output logic            m_tlast     // run_last
);
    import wxt_pkg::*;

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_final_reg;

    scan_t      scan_reg;
    scan_t      scan_next;
    res_t       step_res;
    logic       out_free;
    logic       in_go;
    logic       load;

    // the registered byte moves on once the serializer can take its beats
    assign in_go    = in_valid_reg && out_free;
    assign load     = in_go && ((step_res.flush_cnt != 3'd0) || step_res.extra_vld ||
                                step_res.end_vld);
    assign s_tready = !in_valid_reg || out_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (in_go)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            scan_reg     <= '{mode: MODE_OUT, pos: 3'd0, mask: 5'd0};
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (in_go)
                scan_reg <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_final_reg <= s_tlast;
        end
    end

    wxt_step u_step (
        .in_byte  (in_byte_reg),
        .is_final (in_final_reg),
        .cur      (scan_reg),
        .nxt      (scan_next),
        .res      (step_res)
    );

    wxt_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .res      (step_res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // held match never longer than the longest unfinished pattern
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg.pos <= MAX_HELD)
        else $error("held match length out of range");

    // the document's last byte leaves the scanner in its reset state
    assert property (@(posedge clk) disable iff (!rst_n)
        in_go && in_final_reg |=>
            scan_reg.mode == MODE_OUT && scan_reg.pos == 3'd0 && scan_reg.mask == 5'd0)
        else $error("scan state not cleared after final byte");

    // the end beat is always the last beat of its input byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
        else $error("end beat not last or carries a byte");

    // while skipping an open tag no match is held
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg.mode == MODE_SKIP |-> scan_reg.pos == 3'd0)
        else $error("match held while skipping run tag");

endmodule

`default_nettype wire
